// File: src/json_scalar_value_lexer_defines.svh
// Assertion macros used by the checker file jsvl_checker.sv.
`ifndef JSON_SCALAR_VALUE_LEXER_DEFINES_SVH
`define JSON_SCALAR_VALUE_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define JSVL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define JSVL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/jsvl_pkg.sv
package jsvl_pkg;

   // Lexer modes, one-hot
   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_STR  = 5'b00010,
      MODE_ESC  = 5'b00100,
      MODE_NUM  = 5'b01000,
      MODE_NULL = 5'b10000
   } mode_type;

   // Event codes
   localparam logic [2:0] EV_CHAR = 3'd0;
   localparam logic [2:0] EV_STR  = 3'd1;
   localparam logic [2:0] EV_INT  = 3'd2;
   localparam logic [2:0] EV_DEC  = 3'd3;
   localparam logic [2:0] EV_NULL = 3'd4;
   localparam logic [2:0] EV_ERR  = 3'd5;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
   localparam logic [2:0] ERR_BAD_ESC   = 3'd2;
   localparam logic [2:0] ERR_NULL      = 3'd3;
   localparam logic [2:0] ERR_UNEXPECT  = 3'd4;

   // Characters
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;

   localparam logic [7:0] FRAC_MAX = 8'hFF;

   // One result item
   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  char_out;
      logic [30:0] number_value;
      logic [7:0]  fraction_digits;
      logic        overflowed;
      logic [2:0]  error_kind;
      logic        last_of_item;
   } result_type;

   // Letters of the null literal
   function automatic logic [7:0] null_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = 8'h6E;
         2'd1:    c = 8'h75;
         default: c = 8'h6C;
      endcase
      return c;
   endfunction

endpackage

// File: src/jsvl_core.sv
module jsvl_core #(
   parameter int MANT_W = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             text_byte,
   input  logic                   at_end,
   output jsvl_pkg::result_type   res0,
   output jsvl_pkg::result_type   res1,
   output logic [1:0]             res_count
);

   localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};

   jsvl_pkg::mode_type mode_ff, mode_in;
   logic [1:0]         pos_ff, pos_in;
   logic               point_ff, point_in;
   logic [MANT_W-1:0]  acc_ff, acc_in;
   logic [7:0]         frac_ff, frac_in;
   logic               sat_ff, sat_in;

   logic               is_digit;
   logic [MANT_W+3:0]  acc_next;
   logic               acc_ovf;
   logic [30:0]        acc_ext;

   // Byte class and next mantissa (acc*10 + digit)
   always_comb begin
      case (text_byte) inside
         [jsvl_pkg::CH_0:jsvl_pkg::CH_9]: is_digit = 1'b1;
         default:                         is_digit = 1'b0;
      endcase
      acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
               + (MANT_W+4)'(text_byte[3:0]);
      acc_ovf  = acc_next > (MANT_W+4)'(MANT_MAX);
      acc_ext  = 31'(acc_ff);
   end

   // One lexer step
   always_comb begin
      jsvl_pkg::result_type num_res;
      jsvl_pkg::result_type start_res;
      logic                 start_err;

      mode_in   = mode_ff;
      pos_in    = pos_ff;
      point_in  = point_ff;
      acc_in    = acc_ff;
      frac_in   = frac_ff;
      sat_in    = sat_ff;
      res0      = '0;
      res1      = '0;
      res_count = 2'd0;

      // Number result from the current accumulator
      num_res              = '0;
      num_res.number_value = acc_ext;
      num_res.overflowed   = sat_ff;
      if (point_ff) begin
         num_res.event_res       = jsvl_pkg::EV_DEC;
         num_res.fraction_digits = frac_ff;
      end else begin
         num_res.event_res = jsvl_pkg::EV_INT;
      end

      // Unexpected start byte result
      start_res            = '0;
      start_res.event_res  = jsvl_pkg::EV_ERR;
      start_res.error_kind = jsvl_pkg::ERR_UNEXPECT;
      start_err            = !(text_byte == jsvl_pkg::CH_QUOTE || is_digit ||
                               text_byte == jsvl_pkg::CH_N);

      case (mode_ff)
         jsvl_pkg::MODE_STR: begin
            if (at_end) begin
               mode_in         = jsvl_pkg::MODE_IDLE;
               res0.event_res  = jsvl_pkg::EV_ERR;
               res0.error_kind = jsvl_pkg::ERR_NO_QUOTE;
               res_count       = 2'd1;
            end else if (text_byte == jsvl_pkg::CH_QUOTE) begin
               mode_in        = jsvl_pkg::MODE_IDLE;
               res0.event_res = jsvl_pkg::EV_STR;
               res_count      = 2'd1;
            end else if (text_byte == jsvl_pkg::CH_BSLASH) begin
               mode_in = jsvl_pkg::MODE_ESC;
            end else begin
               res0.event_res = jsvl_pkg::EV_CHAR;
               res0.char_out  = text_byte;
               res_count      = 2'd1;
            end
         end
         jsvl_pkg::MODE_ESC: begin
            res_count = 2'd1;
            if (at_end) begin
               mode_in         = jsvl_pkg::MODE_IDLE;
               res0.event_res  = jsvl_pkg::EV_ERR;
               res0.error_kind = jsvl_pkg::ERR_NO_QUOTE;
            end else if (text_byte == jsvl_pkg::CH_BSLASH ||
                         text_byte == jsvl_pkg::CH_APOS ||
                         text_byte == jsvl_pkg::CH_QUOTE) begin
               mode_in        = jsvl_pkg::MODE_STR;
               res0.event_res = jsvl_pkg::EV_CHAR;
               res0.char_out  = text_byte;
            end else if (text_byte == jsvl_pkg::CH_T) begin
               mode_in        = jsvl_pkg::MODE_STR;
               res0.event_res = jsvl_pkg::EV_CHAR;
               res0.char_out  = jsvl_pkg::CH_TAB;
            end else if (text_byte == jsvl_pkg::CH_N) begin
               mode_in        = jsvl_pkg::MODE_STR;
               res0.event_res = jsvl_pkg::EV_CHAR;
               res0.char_out  = jsvl_pkg::CH_LF;
            end else begin
               mode_in         = jsvl_pkg::MODE_IDLE;
               res0.event_res  = jsvl_pkg::EV_ERR;
               res0.error_kind = jsvl_pkg::ERR_BAD_ESC;
            end
         end
         jsvl_pkg::MODE_NUM: begin
            if (!at_end && is_digit) begin
               if (acc_ovf) begin
                  acc_in = MANT_MAX;
                  sat_in = 1'b1;
               end else begin
                  acc_in = acc_next[MANT_W-1:0];
               end
               if (point_ff && frac_ff != jsvl_pkg::FRAC_MAX) begin
                  frac_in = frac_ff + 8'd1;
               end
            end else if (!at_end && text_byte == jsvl_pkg::CH_POINT && !point_ff) begin
               point_in = 1'b1;
            end else begin
               // Emit the number, then restart on the terminating byte
               res0      = num_res;
               res_count = 2'd1;
               mode_in   = jsvl_pkg::MODE_IDLE;
               point_in  = 1'b0;
               acc_in    = '0;
               frac_in   = 8'd0;
               sat_in    = 1'b0;
               if (!at_end) begin
                  if (start_err) begin
                     res1      = start_res;
                     res_count = 2'd2;
                  end else if (text_byte == jsvl_pkg::CH_QUOTE) begin
                     mode_in = jsvl_pkg::MODE_STR;
                  end else if (is_digit) begin
                     mode_in = jsvl_pkg::MODE_NUM;
                     acc_in  = MANT_W'(text_byte[3:0]);
                  end else begin
                     mode_in = jsvl_pkg::MODE_NULL;
                     pos_in  = 2'd1;
                  end
               end
            end
         end
         jsvl_pkg::MODE_NULL: begin
            if (!at_end && text_byte == jsvl_pkg::null_char(pos_ff)) begin
               pos_in = pos_ff + 2'd1;
               if (pos_ff == 2'd3) begin
                  mode_in        = jsvl_pkg::MODE_IDLE;
                  res0.event_res = jsvl_pkg::EV_NULL;
                  res_count      = 2'd1;
               end
            end else begin
               pos_in          = 2'd0;
               mode_in         = jsvl_pkg::MODE_IDLE;
               res0.event_res  = jsvl_pkg::EV_ERR;
               res0.error_kind = jsvl_pkg::ERR_NULL;
               res_count       = 2'd1;
            end
         end
         default: begin
            mode_in = jsvl_pkg::MODE_IDLE;
            if (!at_end) begin
               if (start_err) begin
                  res0      = start_res;
                  res_count = 2'd1;
               end else if (text_byte == jsvl_pkg::CH_QUOTE) begin
                  mode_in = jsvl_pkg::MODE_STR;
               end else if (is_digit) begin
                  mode_in  = jsvl_pkg::MODE_NUM;
                  point_in = 1'b0;
                  acc_in   = MANT_W'(text_byte[3:0]);
                  frac_in  = 8'd0;
                  sat_in   = 1'b0;
               end else begin
                  mode_in = jsvl_pkg::MODE_NULL;
                  pos_in  = 2'd1;
               end
            end
         end
      endcase

      // Tag the final result of this transfer
      if (res_count == 2'd2) begin
         res1.last_of_item = 1'b1;
      end else if (res_count == 2'd1) begin
         res0.last_of_item = 1'b1;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= jsvl_pkg::MODE_IDLE;
         pos_ff   <= 2'd0;
         point_ff <= 1'b0;
         acc_ff   <= '0;
         frac_ff  <= 8'd0;
         sat_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         point_ff <= point_in;
         acc_ff   <= acc_in;
         frac_ff  <= frac_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

// File: src/jsvl_rsp_fifo.sv
module jsvl_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  jsvl_pkg::result_type push0,
   input  jsvl_pkg::result_type push1,
   input  logic [1:0]           push_count,
   output logic                 room_two,
   output logic                 out_valid,
   input  logic                 out_stall,
   output jsvl_pkg::result_type out_data
);

   jsvl_pkg::result_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign out_valid = cnt_ff != 3'd0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   assign room_two  = cnt_ff <= 3'd2;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      cnt_in    = cnt_ff + {1'b0, push_count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         cnt_ff    <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push1;
      end
   end

endmodule

// File: src/json_scalar_value_lexer.sv
// Streaming lexer for JSON-style scalar values: quoted strings (emitted one
// decoded character per result), integers and decimals (mantissa plus count
// of digits after the point) and the literal null. Bytes enter on the req_
// channel, one per clock when the result side keeps up; each taken byte is
// held in the input register, and its results are written into the result
// queue, which drives rsp_valid. Most bytes give zero or one result; a
// number ended by an unexpected byte gives two, which the result side
// drains in turn. Results wait in a four-entry queue, and the input
// register holds its byte until the queue has room for two. A two-result
// byte always follows a byte that gave none, so unless the result side
// stalls the queue never holds more than two and the sustained rate is one
// byte per cycle.
module json_scalar_value_lexer #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_at_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_char_out,
   output logic [30:0] rsp_number_value,
   output logic [7:0]  rsp_fraction_digits,
   output logic        rsp_overflowed,
   output logic [2:0]  rsp_error_kind,
   output logic        rsp_last_of_item
);

   localparam int MANT_W = (VALUE_WIDTH >= 32) ? 31 : VALUE_WIDTH - 1;

   logic                 in_vld_ff;
   logic [7:0]           byte_ff;
   logic                 end_ff;
   logic                 core_fire;
   logic                 room_two;
   logic [1:0]           res_count;
   logic [1:0]           push_count;
   jsvl_pkg::result_type res0, res1, head;

   assign core_fire  = in_vld_ff && room_two;
   assign req_stall  = in_vld_ff && !core_fire;
   assign push_count = core_fire ? res_count : 2'd0;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_text_byte;
         end_ff  <= req_at_end;
      end
   end

   jsvl_core #(
      .MANT_W (MANT_W)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (core_fire),
      .text_byte (byte_ff),
      .at_end    (end_ff),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   jsvl_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push0      (res0),
      .push1      (res1),
      .push_count (push_count),
      .room_two   (room_two),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (head)
   );

   // Result fields
   assign rsp_event_res       = head.event_res;
   assign rsp_char_out        = head.char_out;
   assign rsp_number_value    = head.number_value;
   assign rsp_fraction_digits = head.fraction_digits;
   assign rsp_overflowed      = head.overflowed;
   assign rsp_error_kind      = head.error_kind;
   assign rsp_last_of_item    = head.last_of_item;

endmodule

// File: src/jsvl_checker.sv
`include "json_scalar_value_lexer_defines.svh"

module jsvl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_text_byte,
   input logic        req_at_end,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_res,
   input logic [7:0]  rsp_char_out,
   input logic [30:0] rsp_number_value,
   input logic [7:0]  rsp_fraction_digits,
   input logic        rsp_overflowed,
   input logic [2:0]  rsp_error_kind,
   input logic        rsp_last_of_item
);

   // Error kind is set exactly on error events
   `JSVL_ASSERT_NOW(a_err_kind, clock, reset, rsp_valid, (rsp_event_res == jsvl_pkg::EV_ERR) == (rsp_error_kind != jsvl_pkg::ERR_NONE), "error kind does not match event")

   // Characters only travel with character events
   `JSVL_ASSERT_NOW(a_char_only, clock, reset, rsp_valid && rsp_event_res != jsvl_pkg::EV_CHAR, rsp_char_out == 8'd0, "char on non-character event")

   // Number fields only on number events
   `JSVL_ASSERT_NOW(a_num_only, clock, reset, rsp_valid && rsp_event_res != jsvl_pkg::EV_INT && rsp_event_res != jsvl_pkg::EV_DEC, rsp_number_value == 31'd0 && !rsp_overflowed, "number on non-number event")

   // Fraction count only on decimal events
   `JSVL_ASSERT_NOW(a_frac_only, clock, reset, rsp_valid && rsp_event_res != jsvl_pkg::EV_DEC, rsp_fraction_digits == 8'd0, "fraction on non-decimal event")

   // A stalled result transfer stays offered
   `JSVL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_res), "stalled result dropped")

endmodule

bind json_scalar_value_lexer jsvl_checker u_jsvl_checker (.*);
